@@ hw/rtl/decimal_text_to_residue_core_assert.svh @@
// Assertion macros shared by the RTL files.
`ifndef DECIMAL_TEXT_TO_RESIDUE_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_RESIDUE_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DTR_ASSERT_NOW(label, clk, rst, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("dtr assertion failed");

// Next-cycle implication, held off during reset.
`define DTR_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("dtr assertion failed");

`endif

@@ hw/rtl/dtr_pkg.sv @@
`timescale 1ns / 1ps
package dtr_pkg;

  localparam int ACC_W   = 64;
  localparam int MOD_W   = 31;
  localparam int REM_W   = MOD_W + 1;
  localparam int COUNT_W = 16;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 8;
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 7;

  localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0]  CH_NINE   = 8'd57;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Register indexes on the config port
  localparam logic [IDX_W-1:0] CFG_MODULUS = 8'd0;
  localparam logic [IDX_W-1:0] CFG_WIDE    = 8'd1;

  // Remainder steps: short run when the dividend is below 16 * modulus
  localparam logic [STEP_W-1:0] STEPS_SHORT = 7'd4;
  localparam logic [STEP_W-1:0] STEPS_FULL  = 7'd64;

  typedef struct packed {
    logic             start;
    logic             short_run;
    logic [ACC_W-1:0] dividend;
    logic [MOD_W-1:0] modulus;
  } rem_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] rem;
  } rem_rsp_t;

endpackage

@@ hw/rtl/dtr_char_if.sv @@
`timescale 1ns / 1ps
interface dtr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

@@ hw/rtl/dtr_result_if.sv @@
`timescale 1ns / 1ps
interface dtr_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [15:0]        digit_count;

  modport source (output valid, output value, output digit_count, input ready);
  modport sink (input valid, input value, input digit_count, output ready);
endinterface

@@ hw/rtl/dtr_cfg_if.sv @@
`timescale 1ns / 1ps
interface dtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/decimal_text_to_residue_core.sv @@
// Decimal text to residue: takes one character byte per beat on chars and gathers
// each run of digits '0'..'9' into an integer. With a nonzero modulus the value is
// reduced after every digit; with modulus zero it wraps at 64 bits. A non-digit byte
// closes the run and emits one beat on results: the value (1 when no digit came),
// truncated and sign extended from 32 bits unless wide_result is set, and the digit
// count, saturating at 65535. Timing is set by the shared restoring remainder unit,
// which retires one dividend bit per cycle. A digit with modulus zero passes through
// the multiply state alone; otherwise it goes on to a short remainder run, or after
// a modulus write to a full 64-bit one, as does the closing byte of a run not yet
// reduced under the new modulus. A non-digit waits in the emit state for the result
// register to drain. Config writes are taken at any cycle and meant for idle.
`timescale 1ns / 1ps
`include "decimal_text_to_residue_core_assert.svh"
module decimal_text_to_residue_core
  import dtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  dtr_char_if.sink          chars,
  dtr_result_if.source      results,
  dtr_cfg_if.sink           cfg
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;

  // config registers
  logic [MOD_W-1:0]   modulus;
  logic               wide_result;

  // run state
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] digits;
  logic               reduced;    // acc zero or acc < modulus under the current modulus
  logic [3:0]         digit;
  logic               div_emit;   // remainder feeds the result, not acc
  logic [ACC_W-1:0]   pend;       // value waiting for the result register

  // result register
  logic               out_valid;
  logic [ACC_W-1:0]   out_value;
  logic [COUNT_W-1:0] out_count;

  logic               in_beat;
  logic               is_digit;
  logic               out_free;
  logic [ACC_W-1:0]   prod;
  logic [CHAR_W-1:0]  char_off;
  logic [COUNT_W-1:0] digits_inc;

  rem_req_t           rem_req;
  rem_rsp_t           rem_rsp;

  assign chars.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_beat     = chars.valid && chars.ready;
  assign is_digit    = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
  assign char_off    = chars.char_code - CH_ZERO;
  assign out_free    = !out_valid || results.ready;

  // acc * 10 + digit as shifts and adds
  assign prod       = {acc[ACC_W-4:0], 3'b000} + {acc[ACC_W-2:0], 1'b0}
                    + {{(ACC_W-4){1'b0}}, digit};
  assign digits_inc = (digits == COUNT_MAX) ? digits : digits + 16'd1;

  always_comb begin
    rem_req.start     = 1'b0;
    rem_req.short_run = 1'b0;
    rem_req.dividend  = prod;
    rem_req.modulus   = modulus;
    case (state)
      ST_IDLE: begin
        // closing byte of a run never reduced under this modulus
        if (in_beat && !is_digit && digits != '0 && modulus != '0 && !reduced) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = acc;
        end
      end
      ST_MUL: begin
        if (modulus != '0) begin
          rem_req.start     = 1'b1;
          rem_req.short_run = reduced;
        end
      end
      default: begin
      end
    endcase
  end

  dtr_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      modulus     <= '0;
      wide_result <= 1'b0;
      acc         <= '0;
      digits      <= '0;
      reduced     <= 1'b1;
      out_valid   <= 1'b0;
      div_emit    <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (is_digit) begin
              digit <= char_off[3:0];
              state <= ST_MUL;
            end else if (digits == '0) begin
              pend  <= {{(ACC_W-1){1'b0}}, 1'b1};
              state <= ST_EMIT;
            end else if (modulus != '0 && !reduced) begin
              div_emit <= 1'b1;
              state    <= ST_DIV;
            end else begin
              pend  <= acc;
              state <= ST_EMIT;
            end
          end
        end
        ST_MUL: begin
          if (modulus == '0) begin
            acc     <= prod;
            reduced <= 1'b0;
            digits  <= digits_inc;
            state   <= ST_IDLE;
          end else begin
            div_emit <= 1'b0;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_rsp.done) begin
            if (div_emit) begin
              pend  <= {{(ACC_W-MOD_W){1'b0}}, rem_rsp.rem};
              state <= ST_EMIT;
            end else begin
              acc     <= {{(ACC_W-MOD_W){1'b0}}, rem_rsp.rem};
              reduced <= 1'b1;
              digits  <= digits_inc;
              state   <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_value <= wide_result ? pend : {{32{pend[31]}}, pend[31:0]};
            out_count <= digits;
            acc       <= '0;
            digits    <= '0;
            reduced   <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // config last: a modulus write invalidates the reduced mark
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODULUS: begin
            modulus <= cfg.data[MOD_W-1:0];
            reduced <= 1'b0;
          end
          CFG_WIDE: begin
            wide_result <= cfg.data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.value       = out_value;
  assign results.digit_count = out_count;

  `DTR_ASSERT_NOW(a_empty_run, clk, rst, out_valid && out_count == '0, out_value == 64'd1)
  `DTR_ASSERT_NEXT(a_digit_mul, clk, rst, in_beat && is_digit, state == ST_MUL)
  `DTR_ASSERT_NEXT(a_div_exit, clk, rst, state == ST_DIV && rem_rsp.done,
                   state == ST_IDLE || state == ST_EMIT)

endmodule

@@ hw/rtl/dtr_rem_unit.sv @@
`timescale 1ns / 1ps
`include "decimal_text_to_residue_core_assert.svh"
// Restoring remainder, one dividend bit per cycle.
module dtr_rem_unit
  import dtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [REM_W-1:0]  rem;
  logic [ACC_W-1:0]  shreg;
  logic [MOD_W-1:0]  mod_l;

  logic [REM_W-1:0]  trial;
  logic              fits;

  assign trial = {rem[REM_W-2:0], shreg[ACC_W-1]};
  assign fits  = trial >= {1'b0, mod_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem   <= fits ? trial - {1'b0, mod_l} : trial;
        shreg <= {shreg[ACC_W-2:0], 1'b0};
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy  <= 1'b1;
        mod_l <= req.modulus;
        if (req.short_run) begin
          // dividend < 16*m, so its top bits are already a remainder
          rem   <= {1'b0, req.dividend[MOD_W+3:4]};
          shreg <= {req.dividend[3:0], {(ACC_W-4){1'b0}}};
          steps <= STEPS_SHORT;
        end else begin
          rem   <= '0;
          shreg <= req.dividend;
          steps <= STEPS_FULL;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem[MOD_W-1:0];

  `DTR_ASSERT_NOW(a_start_mod, clk, rst, req.start && !busy, req.modulus != '0)
  `DTR_ASSERT_NOW(a_rem_below, clk, rst, busy, rem < {1'b0, mod_l})
  `DTR_ASSERT_NEXT(a_last_step, clk, rst, busy && steps == 7'd1, done && !busy)

endmodule
